// ----- rtl/core/esd_pkg.sv -----
// Shared widths, status codes and sideband type for the ellipse shape pipeline.
package esd_pkg;

    // Value format (unsigned fixed point)
    localparam int VW   = 32;           // value width
    localparam int FB   = 16;           // fraction bits
    localparam int SQW  = 2 * VW;       // square of a side
    localparam int FACW = SQW + 1;      // one denominator factor
    localparam int DENW = 2 * FACW;     // denominator
    localparam int SUMW = VW + 2;       // Heron sums
    localparam int PRW  = 2 * SUMW;     // product of two Heron sums
    localparam int NUMW = 2 * PRW;      // numerator
    localparam int RHSW = NUMW + 2 * FB; // numerator scaled by 2^(2*FB)
    localparam int QW   = 2 * VW;       // quotient before square root
    localparam int RDW  = VW + 1;       // reciprocal divisor / dividend
    localparam int DFW  = FB + 3;       // distance factor width

    localparam logic [VW-1:0] CUTOFF_RST = VW'(100) << FB;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BEYOND  = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    // Sideband that travels with each transaction
    typedef struct packed {
        logic [1:0] status;
        logic       sat;
    } tag_t;

endpackage

// ----- rtl/core/esd_mul.sv -----
// Two-stage multiplier built from four half-width partial products.
module esd_mul #(
    parameter int AW = 68,
    parameter int BW = 68
) (
    input  logic             clk,
    input  logic             en,
    input  logic [AW-1:0]    a,
    input  logic [BW-1:0]    b,
    output logic [AW+BW-1:0] p
);
    localparam int AL = AW / 2;
    localparam int AH = AW - AL;
    localparam int BL = BW / 2;
    localparam int BH = BW - BL;
    localparam int PW = AW + BW;

    logic [AL+BL-1:0] ll_reg;
    logic [AL+BH-1:0] lh_reg;
    logic [AH+BL-1:0] hl_reg;
    logic [AH+BH-1:0] hh_reg;
    logic [PW-1:0]    p_reg;

    // partial products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ll_reg <= (AL+BL)'(a[AL-1:0]) * (AL+BL)'(b[BL-1:0]);
            lh_reg <= (AL+BH)'(a[AL-1:0]) * (AL+BH)'(b[BW-1:BL]);
            hl_reg <= (AH+BL)'(a[AW-1:AL]) * (AH+BL)'(b[BL-1:0]);
            hh_reg <= (AH+BH)'(a[AW-1:AL]) * (AH+BH)'(b[BW-1:BL]);
        end
    end

    // recombine
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= PW'(ll_reg) + (PW'(lh_reg) << AL) + (PW'(hl_reg) << BL)
                   + (PW'(hh_reg) << (AL + BL));
        end
    end

    assign p = p_reg;
endmodule

// ----- rtl/core/esd_divq.sv -----
// Pipelined restoring divider: floor(num * 2^(2*FB) / den), one quotient bit per stage.
module esd_divq (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     in_vld,
    input  logic [esd_pkg::NUMW-1:0] num,
    input  logic [esd_pkg::DENW-1:0] den,
    input  esd_pkg::tag_t            in_tag,
    output logic                     out_vld,
    output logic [esd_pkg::QW-1:0]   quo,
    output esd_pkg::tag_t            out_tag
);
    import esd_pkg::*;

    localparam int TW = DENW + QW;

    logic            vld_reg [0:QW];
    logic [RHSW-1:0] rem_reg [0:QW];
    logic [DENW-1:0] den_reg [0:QW];
    logic [QW-1:0]   quo_reg [0:QW];
    tag_t            tag_reg [0:QW];
    tag_t            tag_next;

    // quotient would need more than QW bits
    always_comb
    begin
        tag_next     = in_tag;
        tag_next.sat = (TW'(num) >= (TW'(den) << VW));
    end

    // entry stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (en)
            vld_reg[0] <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= {num, VW'(0)};
            den_reg[0] <= den;
            quo_reg[0] <= '0;
            tag_reg[0] <= tag_next;
        end
    end

    // one quotient bit per stage, most significant first
    for (genvar k = 0; k < QW; k++)
    begin : g_stage
        localparam int SH = QW - 1 - k;
        logic [TW-1:0] trial;
        logic [TW-1:0] remx;
        logic          ge;

        assign trial = TW'(den_reg[k]) << SH;
        assign remx  = TW'(rem_reg[k]);
        assign ge    = (remx >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k+1] <= 1'b0;
            else if (en)
                vld_reg[k+1] <= vld_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1] <= ge ? RHSW'(remx - trial) : rem_reg[k];
                den_reg[k+1] <= den_reg[k];
                quo_reg[k+1] <= quo_reg[k] | (QW'(ge) << SH);
                tag_reg[k+1] <= tag_reg[k];
            end
        end
    end

    assign out_vld = vld_reg[QW];
    assign quo     = quo_reg[QW];
    assign out_tag = tag_reg[QW];
endmodule

// ----- rtl/core/esd_sqrt.sv -----
// Pipelined integer square root, two radicand bits per stage.
module esd_sqrt (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_vld,
    input  logic [esd_pkg::QW-1:0] rad,
    input  esd_pkg::tag_t          in_tag,
    output logic                   out_vld,
    output logic [esd_pkg::VW-1:0] root,
    output esd_pkg::tag_t          out_tag
);
    import esd_pkg::*;

    localparam int RW = VW + 2;

    logic          vld_reg  [0:VW];
    logic [QW-1:0] rad_reg  [0:VW];
    logic [RW-1:0] rem_reg  [0:VW];
    logic [VW-1:0] root_reg [0:VW];
    tag_t          tag_reg  [0:VW];

    // entry stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (en)
            vld_reg[0] <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg[0]  <= rad;
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            tag_reg[0]  <= in_tag;
        end
    end

    // one root bit per stage
    for (genvar k = 0; k < VW; k++)
    begin : g_stage
        localparam int BP = 2 * (VW - 1 - k);
        logic [RW-1:0] remx;
        logic [RW-1:0] trial;
        logic          ge;

        assign remx  = {rem_reg[k][VW-1:0], rad_reg[k][BP+1 -: 2]};
        assign trial = {root_reg[k], 2'b01};
        assign ge    = (remx >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k+1] <= 1'b0;
            else if (en)
                vld_reg[k+1] <= vld_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[k+1]  <= rad_reg[k];
                rem_reg[k+1]  <= ge ? (remx - trial) : remx;
                root_reg[k+1] <= {root_reg[k][VW-2:0], ge};
                tag_reg[k+1]  <= tag_reg[k];
            end
        end
    end

    assign out_vld = vld_reg[VW];
    assign root    = root_reg[VW];
    assign out_tag = tag_reg[VW];
endmodule

// ----- rtl/core/esd_recip.sv -----
// Pipelined divider for floor(2^(2*FB) / (shape + 0.25)), one bit per stage.
module esd_recip (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_vld,
    input  logic [esd_pkg::VW-1:0]  shape,
    input  esd_pkg::tag_t           in_tag,
    output logic                    out_vld,
    output logic [esd_pkg::VW-1:0]  out_shape,
    output logic [esd_pkg::DFW-1:0] quo,
    output esd_pkg::tag_t           out_tag
);
    import esd_pkg::*;

    localparam int TW = RDW + DFW;

    logic           vld_reg   [0:DFW];
    logic [RDW-1:0] rem_reg   [0:DFW];
    logic [RDW-1:0] dvs_reg   [0:DFW];
    logic [DFW-1:0] quo_reg   [0:DFW];
    logic [VW-1:0]  shape_reg [0:DFW];
    tag_t           tag_reg   [0:DFW];

    // entry stage: divisor = shape + 0.25, dividend = 1.0 squared
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (en)
            vld_reg[0] <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]   <= RDW'(1) << (2 * FB);
            dvs_reg[0]   <= RDW'(shape) + (RDW'(1) << (FB - 2));
            quo_reg[0]   <= '0;
            shape_reg[0] <= shape;
            tag_reg[0]   <= in_tag;
        end
    end

    for (genvar k = 0; k < DFW; k++)
    begin : g_stage
        localparam int SH = DFW - 1 - k;
        logic [TW-1:0] trial;
        logic [TW-1:0] remx;
        logic          ge;

        assign trial = TW'(dvs_reg[k]) << SH;
        assign remx  = TW'(rem_reg[k]);
        assign ge    = (remx >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k+1] <= 1'b0;
            else if (en)
                vld_reg[k+1] <= vld_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1]   <= ge ? RDW'(remx - trial) : rem_reg[k];
                dvs_reg[k+1]   <= dvs_reg[k];
                quo_reg[k+1]   <= quo_reg[k] | (DFW'(ge) << SH);
                shape_reg[k+1] <= shape_reg[k];
                tag_reg[k+1]   <= tag_reg[k];
            end
        end
    end

    assign out_vld   = vld_reg[DFW];
    assign out_shape = shape_reg[DFW];
    assign quo       = quo_reg[DFW];
    assign out_tag   = tag_reg[DFW];
endmodule

// ----- rtl/core/ellipse_shape_from_distances_core.sv -----
// Top level of the ellipse shape pipeline: side checks, products, divide, root, factor.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+---------------------------------------------
//   input    | in_valid / in_ready       | side_a, side_b, side_c
//   output   | out_valid / out_ready     | status, shape_value, beyond_cutoff,
//            |                           | distance_factor
//   config   | cfg_we (no wait)          | cfg_wdata -> shape cutoff
//
// One transaction per cycle unless a full output register with out_ready low stalls it;
// 123 register stages, most of them in the 64-stage quotient divider, the 32-stage
// square root and the 19-stage factor divider.
// Reset clears all valid bits and loads the cutoff with 100.0.
// A full output register with out_ready low freezes the whole pipeline in place.
module ellipse_shape_from_distances_core (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [31:0]             side_a,
    input  logic [31:0]             side_b,
    input  logic [31:0]             side_c,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [1:0]              status,
    output logic [31:0]             shape_value,
    output logic                    beyond_cutoff,
    output logic [18:0]             distance_factor,
    input  logic                    cfg_we,
    input  logic [31:0]             cfg_wdata
);
    import esd_pkg::*;

    logic en;

    logic [VW-1:0] cutoff_reg;

    // stage 2: squares and Heron sums
    logic            v2_reg;
    logic [SQW-1:0]  a2_reg, b2_reg, c2_reg;
    logic [SUMW-1:0] sa_reg, sb_reg, sc_reg, sd_reg;
    logic            zero_reg, long_reg;

    // stage 3: classification and first products
    logic            v3_reg;
    tag_t            t3_reg, t3_next;
    logic [FACW-1:0] f1_reg, f2_reg;
    logic [PRW-1:0]  p1_reg, p2_reg;
    logic            foot_out;

    // stages 4 and 5: wide multipliers
    logic            v4_reg, v5_reg;
    tag_t            t4_reg, t5_reg;
    logic [DENW-1:0] den;
    logic [NUMW-1:0] num;

    logic          dq_vld;
    logic [QW-1:0] dq_quo;
    tag_t          dq_tag;

    logic          sq_vld;
    logic [VW-1:0] sq_root;
    tag_t          sq_tag;
    logic [VW-1:0] sq_shape;

    logic           rc_vld;
    logic [VW-1:0]  rc_shape;
    logic [DFW-1:0] rc_quo;
    tag_t           rc_tag;

    logic           out_vld_reg;
    logic [1:0]     status_reg;
    logic [VW-1:0]  shape_reg;
    logic           cut_reg;
    logic [DFW-1:0] df_reg;

    assign en       = !out_vld_reg || out_ready;
    assign in_ready = en;

    // shape cutoff register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cutoff_reg <= CUTOFF_RST;
        else if (cfg_we)
            cutoff_reg <= cfg_wdata;
    end

    // valid bits of the front stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v2_reg <= in_valid;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // squares, Heron sums, zero side and long axis
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a2_reg   <= SQW'(side_a) * SQW'(side_a);
            b2_reg   <= SQW'(side_b) * SQW'(side_b);
            c2_reg   <= SQW'(side_c) * SQW'(side_c);
            sa_reg   <= SUMW'(side_a) + SUMW'(side_b) + SUMW'(side_c);
            sb_reg   <= SUMW'(side_b) + SUMW'(side_c) - SUMW'(side_a);
            sc_reg   <= SUMW'(side_a) + SUMW'(side_c) - SUMW'(side_b);
            sd_reg   <= SUMW'(side_a) + SUMW'(side_b) - SUMW'(side_c);
            zero_reg <= (side_a == '0) || (side_b == '0) || (side_c == '0);
            long_reg <= (RDW'(side_c) > (RDW'(side_a) + RDW'(side_b)));
        end
    end

    // foot of the height outside or on an end of the axis
    assign foot_out = (FACW'(b2_reg) >= (FACW'(a2_reg) + FACW'(c2_reg)))
                   || (FACW'(a2_reg) >= (FACW'(b2_reg) + FACW'(c2_reg)));

    always_comb
    begin
        t3_next.sat = 1'b0;
        if (zero_reg)
            t3_next.status = ST_INVALID;
        else if (foot_out)
            t3_next.status = ST_BEYOND;
        else if (long_reg)
            t3_next.status = ST_INVALID;
        else
            t3_next.status = ST_OK;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t3_reg <= t3_next;
            f1_reg <= FACW'(c2_reg) + FACW'(a2_reg) - FACW'(b2_reg);
            f2_reg <= FACW'(c2_reg) + FACW'(b2_reg) - FACW'(a2_reg);
            p1_reg <= PRW'(sa_reg) * PRW'(sb_reg);
            p2_reg <= PRW'(sc_reg) * PRW'(sd_reg);
            t4_reg <= t3_reg;
            t5_reg <= t4_reg;
        end
    end

    // denominator and numerator
    esd_mul #(.AW(FACW), .BW(FACW)) u_mul_den (
        .clk (clk),
        .en  (en),
        .a   (f1_reg),
        .b   (f2_reg),
        .p   (den)
    );

    esd_mul #(.AW(PRW), .BW(PRW)) u_mul_num (
        .clk (clk),
        .en  (en),
        .a   (p1_reg),
        .b   (p2_reg),
        .p   (num)
    );

    esd_divq u_divq (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (v5_reg),
        .num     (num),
        .den     (den),
        .in_tag  (t5_reg),
        .out_vld (dq_vld),
        .quo     (dq_quo),
        .out_tag (dq_tag)
    );

    esd_sqrt u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (dq_vld),
        .rad     (dq_quo),
        .in_tag  (dq_tag),
        .out_vld (sq_vld),
        .root    (sq_root),
        .out_tag (sq_tag)
    );

    // saturate the shape when the quotient overflowed
    assign sq_shape = sq_tag.sat ? '1 : sq_root;

    esd_recip u_recip (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_vld    (sq_vld),
        .shape     (sq_shape),
        .in_tag    (sq_tag),
        .out_vld   (rc_vld),
        .out_shape (rc_shape),
        .quo       (rc_quo),
        .out_tag   (rc_tag)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= rc_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            status_reg <= rc_tag.status;
            if (rc_tag.status != ST_OK)
            begin
                shape_reg <= '1;
                cut_reg   <= 1'b1;
                df_reg    <= DFW'(1) << FB;
            end
            else
            begin
                shape_reg <= rc_shape;
                cut_reg   <= (rc_shape > cutoff_reg);
                df_reg    <= (DFW'(1) << FB) + rc_quo;
            end
        end
    end

    assign out_valid       = out_vld_reg;
    assign status          = status_reg;
    assign shape_value     = shape_reg;
    assign beyond_cutoff   = cut_reg;
    assign distance_factor = df_reg;
endmodule
